// File: rtl/cmdu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the TLV message stream parser.
// No dependencies; the parser core, event queue and top level refer to this package by scoped names.
package cmdu_pkg;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER    = 5'b00001,
    PH_TLVHDR    = 5'b00010,
    PH_VALUE     = 5'b00100,
    PH_AFTER_END = 5'b01000,
    PH_TRAIL     = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER = 3'd0,
    EV_TLV    = 3'd1,
    EV_VALUE  = 3'd2,
    EV_OK     = 3'd3,
    EV_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE_OR_SHORT = 3'd0,  // short header (also the idle value)
    ERR_PART_TLV      = 3'd1,
    ERR_TRUNC_VALUE   = 3'd2,
    ERR_TRAILING      = 3'd3,
    ERR_NO_END        = 3'd4
  } err_e;

  // One result transaction
  typedef struct packed {
    kind_e       event_kind;
    logic [15:0] message_type;
    logic [15:0] message_id;
    logic [7:0]  message_flags;
    logic [15:0] element_type;
    logic [15:0] element_length;
    logic [7:0]  value_byte;
    err_e        error_code;
    logic        last_of_run;
  } evt_t;

  // Results produced by one accepted byte (0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    evt_t       evt0;
    evt_t       evt1;
  } push_t;

  localparam int unsigned QDEPTH = 4;

endpackage

// File: rtl/cmdu_in_if.sv
`timescale 1ns / 1ps
// Byte input channel: valid/ready plus one message byte and its final flag.
// No dependencies.
interface cmdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: rtl/cmdu_out_if.sv
`timescale 1ns / 1ps
// Event output channel: valid/ready plus the parser result fields.
// No dependencies.
interface cmdu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] message_type;
  logic [15:0] message_id;
  logic [7:0]  message_flags;
  logic [15:0] element_type;
  logic [15:0] element_length;
  logic [7:0]  value_byte;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (
    output valid, input ready,
    output event_kind, output message_type, output message_id, output message_flags,
    output element_type, output element_length, output value_byte, output error_code,
    output last_of_run
  );
  modport sink (
    input valid, output ready,
    input event_kind, input message_type, input message_id, input message_flags,
    input element_type, input element_length, input value_byte, input error_code,
    input last_of_run
  );
endinterface

// File: rtl/cmdu_parse_core.sv
`timescale 1ns / 1ps
// Parser state registers and per-byte next-state / event logic.
// Depends on cmdu_pkg.
module cmdu_parse_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  logic [15:0]         end_code_i,
  output cmdu_pkg::push_t     push_o
);

  cmdu_pkg::phase_e phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] htype_q, htype_d;
  logic [15:0] hid_q, hid_d;
  logic [7:0]  hflags_q, hflags_d;
  logic [15:0] etype_q, etype_d;
  logic [15:0] dlen_q, dlen_d;
  logic [15:0] rlen_q, rlen_d;
  logic        end_seen_q, end_seen_d;

  logic            byte_evt;
  cmdu_pkg::evt_t  evt_byte;
  cmdu_pkg::evt_t  evt_verdict;
  cmdu_pkg::push_t push;

  function automatic cmdu_pkg::evt_t mk_evt(
    input cmdu_pkg::kind_e kind,
    input logic            hdr_ok,
    input logic [15:0]     ht,
    input logic [15:0]     hi,
    input logic [7:0]      hf,
    input logic            with_elem,
    input logic [15:0]     et,
    input logic [15:0]     dl,
    input logic [7:0]      vb,
    input cmdu_pkg::err_e  err
  );
    cmdu_pkg::evt_t e;
    e.event_kind     = kind;
    e.message_type   = hdr_ok ? ht : 16'h0;
    e.message_id     = hdr_ok ? hi : 16'h0;
    e.message_flags  = hdr_ok ? hf : 8'h0;
    e.element_type   = with_elem ? et : 16'h0;
    e.element_length = with_elem ? dl : 16'h0;
    e.value_byte     = vb;
    e.error_code     = err;
    e.last_of_run    = 1'b0;
    return e;
  endfunction

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    htype_d    = htype_q;
    hid_d      = hid_q;
    hflags_d   = hflags_q;
    etype_d    = etype_q;
    dlen_d     = dlen_q;
    rlen_d     = rlen_q;
    end_seen_d = end_seen_q;
    byte_evt   = 1'b0;
    evt_byte   = '0;
    evt_verdict = '0;
    push       = '0;

    // byte handling
    unique case (phase_q)
      cmdu_pkg::PH_HEADER: begin
        case (idx_q)
          3'd0:    htype_d  = {data_byte_i, 8'h00};
          3'd1:    htype_d  = {htype_q[15:8], data_byte_i};
          3'd2:    hid_d    = {data_byte_i, 8'h00};
          3'd3:    hid_d    = {hid_q[15:8], data_byte_i};
          3'd4:    hflags_d = data_byte_i;
          default: ;
        endcase
        if (idx_q >= 3'd5) begin
          phase_d  = cmdu_pkg::PH_TLVHDR;
          idx_d    = 3'd0;
          byte_evt = 1'b1;
          evt_byte = mk_evt(cmdu_pkg::EV_HEADER, 1'b1, htype_d, hid_d, hflags_d,
                            1'b0, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_NONE_OR_SHORT);
        end else begin
          idx_d = 3'(idx_q + 3'd1);
        end
      end
      cmdu_pkg::PH_TLVHDR: begin
        case (idx_q[1:0])
          2'd0:    etype_d = {data_byte_i, 8'h00};
          2'd1:    etype_d = {etype_q[15:8], data_byte_i};
          2'd2:    dlen_d  = {data_byte_i, 8'h00};
          default: dlen_d  = {dlen_q[15:8], data_byte_i};
        endcase
        if (idx_q >= 3'd3) begin
          idx_d      = 3'd0;
          rlen_d     = dlen_d;
          end_seen_d = (etype_d == end_code_i);
          byte_evt   = 1'b1;
          evt_byte   = mk_evt(cmdu_pkg::EV_TLV, 1'b1, htype_q, hid_q, hflags_q,
                              1'b1, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_NONE_OR_SHORT);
          if (dlen_d != 16'h0) begin
            phase_d = cmdu_pkg::PH_VALUE;
          end else if (end_seen_d) begin
            phase_d = cmdu_pkg::PH_AFTER_END;
          end
        end else begin
          idx_d = 3'(idx_q + 3'd1);
        end
      end
      cmdu_pkg::PH_VALUE: begin
        byte_evt = 1'b1;
        evt_byte = mk_evt(cmdu_pkg::EV_VALUE, 1'b1, htype_q, hid_q, hflags_q,
                          1'b1, etype_q, dlen_q, data_byte_i, cmdu_pkg::ERR_NONE_OR_SHORT);
        rlen_d = 16'(rlen_q - 16'd1);
        if (rlen_d == 16'h0) begin
          phase_d = end_seen_q ? cmdu_pkg::PH_AFTER_END : cmdu_pkg::PH_TLVHDR;
        end
      end
      cmdu_pkg::PH_AFTER_END: phase_d = cmdu_pkg::PH_TRAIL;
      default:                phase_d = cmdu_pkg::PH_TRAIL;
    endcase

    // verdict on the final byte, by where the byte left the parser
    unique case (phase_d)
      cmdu_pkg::PH_HEADER:
        evt_verdict = mk_evt(cmdu_pkg::EV_ERROR, 1'b0, htype_d, hid_d, hflags_d,
                             1'b0, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_NONE_OR_SHORT);
      cmdu_pkg::PH_TLVHDR:
        evt_verdict = mk_evt(cmdu_pkg::EV_ERROR, 1'b1, htype_d, hid_d, hflags_d,
                             1'b0, etype_d, dlen_d, 8'h00,
                             (idx_d != 3'd0) ? cmdu_pkg::ERR_PART_TLV : cmdu_pkg::ERR_NO_END);
      cmdu_pkg::PH_VALUE:
        evt_verdict = mk_evt(cmdu_pkg::EV_ERROR, 1'b1, htype_d, hid_d, hflags_d,
                             1'b0, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_TRUNC_VALUE);
      cmdu_pkg::PH_AFTER_END:
        evt_verdict = mk_evt(cmdu_pkg::EV_OK, 1'b1, htype_d, hid_d, hflags_d,
                             1'b0, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_NONE_OR_SHORT);
      default:
        evt_verdict = mk_evt(cmdu_pkg::EV_ERROR, 1'b1, htype_d, hid_d, hflags_d,
                             1'b0, etype_d, dlen_d, 8'h00, cmdu_pkg::ERR_TRAILING);
    endcase
    evt_verdict.last_of_run = 1'b1;

    // pack results in order
    if (final_byte_i) begin
      if (byte_evt) begin
        push.count = 2'd2;
        push.evt0  = evt_byte;
        push.evt1  = evt_verdict;
      end else begin
        push.count = 2'd1;
        push.evt0  = evt_verdict;
      end
      // restart for the next message
      phase_d    = cmdu_pkg::PH_HEADER;
      idx_d      = 3'd0;
      htype_d    = 16'h0;
      hid_d      = 16'h0;
      hflags_d   = 8'h0;
      etype_d    = 16'h0;
      dlen_d     = 16'h0;
      rlen_d     = 16'h0;
      end_seen_d = 1'b0;
    end else if (byte_evt) begin
      push.count = 2'd1;
      push.evt0  = evt_byte;
      push.evt0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cmdu_pkg::PH_HEADER;
      idx_q      <= 3'd0;
      htype_q    <= 16'h0;
      hid_q      <= 16'h0;
      hflags_q   <= 8'h0;
      etype_q    <= 16'h0;
      dlen_q     <= 16'h0;
      rlen_q     <= 16'h0;
      end_seen_q <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      htype_q    <= htype_d;
      hid_q      <= hid_d;
      hflags_q   <= hflags_d;
      etype_q    <= etype_d;
      dlen_q     <= dlen_d;
      rlen_q     <= rlen_d;
      end_seen_q <= end_seen_d;
    end
  end

  always_comb begin
    push_o = push;
    if (!fire_i) begin
      push_o.count = 2'd0;
    end
  end

endmodule

// File: rtl/cmdu_evt_queue.sv
`timescale 1ns / 1ps
// Shifting result queue: takes up to two events per cycle, presents one.
// Depends on cmdu_pkg.
module cmdu_evt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmdu_pkg::push_t push_i,
  input  logic            pop_i,
  output cmdu_pkg::evt_t  head_o,
  output logic            valid_o,
  output logic            space_o
);

  localparam int unsigned CntW = $clog2(cmdu_pkg::QDEPTH + 1);

  cmdu_pkg::evt_t slot_q [cmdu_pkg::QDEPTH];
  cmdu_pkg::evt_t slot_d [cmdu_pkg::QDEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] base;
  logic            do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[0];
  // room for the worst case of two events
  assign space_o = (cnt_q <= CntW'(cmdu_pkg::QDEPTH - 2));

  always_comb begin
    base  = CntW'(cnt_q - CntW'(do_pop));
    cnt_d = CntW'(base + CntW'(push_i.count));
    for (int i = 0; i < cmdu_pkg::QDEPTH; i++) begin
      if (do_pop && (i + 1 < cmdu_pkg::QDEPTH)) begin
        slot_d[i] = slot_q[i + 1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if ((push_i.count != 2'd0) && (CntW'(i) == base)) begin
        slot_d[i] = push_i.evt0;
      end
      if ((push_i.count == 2'd2) && (CntW'(i) == CntW'(base + CntW'(1)))) begin
        slot_d[i] = push_i.evt1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cmdu_pkg::QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/cmdu_tlv_stream_parser.sv
`timescale 1ns / 1ps
// Top level of the TLV message stream parser: config register, parser core, event queue.
// Depends on cmdu_pkg, cmdu_in_if, cmdu_out_if, cmdu_parse_core, cmdu_evt_queue.
//
//  channel  | dir | handshake     | transaction
//  ---------+-----+---------------+----------------------------------------------
//  msg_i    | in  | valid/ready   | one message byte + final flag
//  evt_o    | out | valid/ready   | one event (header, tlv, value, ok, error)
//  cfg      | in  | cfg_we_i      | end-of-message TLV type code (16 bit)
//
// One byte per clock while the queue can take two events. A byte is parsed in
// the cycle it is accepted; its events land in a 4-deep event queue and reach
// evt_o behind any events already queued. msg_i.ready is high while the queue
// holds two events or fewer, so sink stalls reach msg_i only once it holds more;
// the byte side never waits on evt_o.ready combinationally. A final byte may produce two events.
// Reset clears parser state, queue count and the end code (0).
module cmdu_tlv_stream_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  cmdu_in_if.sink           msg_i,
  cmdu_out_if.source        evt_o
);

  logic [15:0]     end_code_q;
  logic            fire;
  logic            space;
  cmdu_pkg::push_t push;
  cmdu_pkg::evt_t  head;

  // end TLV code, written on cfg_we_i; the core compares it when a TLV header completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_code_q <= 16'h0;
    end else if (cfg_we_i) begin
      end_code_q <= cfg_wdata_i;
    end
  end

  assign msg_i.ready = space;
  assign fire        = msg_i.valid && space;

  cmdu_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (msg_i.data_byte),
    .final_byte_i (msg_i.final_byte),
    .end_code_i   (end_code_q),
    .push_o       (push)
  );

  cmdu_evt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (evt_o.ready),
    .head_o  (head),
    .valid_o (evt_o.valid),
    .space_o (space)
  );

  // unpack the head event onto the channel
  assign evt_o.event_kind     = head.event_kind;
  assign evt_o.message_type   = head.message_type;
  assign evt_o.message_id     = head.message_id;
  assign evt_o.message_flags  = head.message_flags;
  assign evt_o.element_type   = head.element_type;
  assign evt_o.element_length = head.element_length;
  assign evt_o.value_byte     = head.value_byte;
  assign evt_o.error_code     = head.error_code;
  assign evt_o.last_of_run    = head.last_of_run;

endmodule
